// ----- hw/rtl/bir_pkg.sv -----
// bir_pkg: shared types and constants for the bilinear image resize block
// used by bilinear_image_resize and bir_div; depends on nothing else
`default_nettype none

package bir_pkg;

   // source plane geometry
   localparam int MAX_SOURCE_ROWS = 256;
   localparam int MAX_SOURCE_COLS = 256;
   localparam int PIXEL_BITS      = 16;
   localparam int ROW_BITS        = $clog2(MAX_SOURCE_ROWS);
   localparam int COL_BITS        = $clog2(MAX_SOURCE_COLS);
   localparam int ADDR_BITS       = ROW_BITS + COL_BITS;
   localparam int SOURCE_DEPTH    = MAX_SOURCE_ROWS * MAX_SOURCE_COLS;

   // field and register widths
   localparam int COORD_BITS      = 12;
   localparam int SRC_SIZE_BITS   = 9;
   localparam int DST_SIZE_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 13;

   // fixed point coordinate and divider sizing
   localparam int FRAC_BITS       = 16;
   localparam int QUOT_BITS       = 24;
   localparam int NUMER_BITS      = 37;
   localparam int DENOM_BITS      = DST_SIZE_BITS + 1;
   localparam int WEIGHT_BITS     = FRAC_BITS + 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ALIGN_CORNERS = 3'd4;

   // action codes
   localparam logic ACT_STORE   = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   typedef struct packed {
      logic                         action;
      logic [COORD_BITS-1:0]        row;
      logic [COORD_BITS-1:0]        col;
      logic signed [PIXEL_BITS-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] value;
      logic                         out_of_range;
   } rsp_type;

   // lower neighbor index and blend weight of one axis
   typedef struct packed {
      logic [ROW_BITS-1:0]    base;
      logic [WEIGHT_BITS-1:0] frac;
   } axis_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bir_div.sv -----
// bir_div: radix-2 restoring divider, one quotient bit per cycle
// depends on bir_pkg for the numerator, denominator and quotient widths
`default_nettype none

module bir_div
   import bir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [NUMER_BITS-1:0] numer,
   input  logic [DENOM_BITS-1:0] denom,
   output logic [QUOT_BITS-1:0]  quot,
   output logic                  done
);

   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic [DENOM_BITS-1:0] rem_ff, rem_in;
   logic [DENOM_BITS-1:0] den_ff;
   logic [QUOT_BITS-1:0]  work_ff, work_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [DENOM_BITS+1:0] trial;
   logic                  take;

   // partial remainder with the next numerator bit shifted in
   always_comb begin
      trial   = {1'b0, rem_ff, work_ff[QUOT_BITS-1]} - {2'b00, den_ff};
      take    = !trial[DENOM_BITS+1];
      rem_in  = take ? trial[DENOM_BITS-1:0] : {rem_ff[DENOM_BITS-2:0], work_ff[QUOT_BITS-1]};
      work_in = {work_ff[QUOT_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_BITS'(QUOT_BITS);
      end else if (run_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         run_ff  <= (cnt_ff != CNT_BITS'(1));
         done_ff <= (cnt_ff == CNT_BITS'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= DENOM_BITS'(numer[NUMER_BITS-1:QUOT_BITS]);
         work_ff <= numer[QUOT_BITS-1:0];
         den_ff  <= denom;
      end else if (run_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign quot = work_ff;
   assign done = done_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> run_ff && cnt_ff == CNT_BITS'(QUOT_BITS))
      else $error("divider did not start on load");

endmodule

`default_nettype wire

// ----- hw/rtl/bilinear_image_resize.sv -----
// channel   ports                                   direction  handshake
// request   start, busy, req_item                   in         start && !busy
// result    rsp_strobe, rsp_item                    out        one-cycle strobe, no stall
// config    csr_write_en, csr_index, csr_data       in         write on csr_write_en
//
// a store word is written as it is accepted and a flagged request strobes its word the next cycle
// an in-range request holds busy while S_DIV runs the two per-axis 24-step dividers,
// S_COORD splits the coordinates, S_RD0 to S_RD3 make one source plane read per neighbor
// on the single memory port and S_MIX and S_FIN blend; the word strobes as busy drops
// the receiver cannot stall results, so busy alone paces the requests
// synchronous reset; the source plane is not cleared
// depends on bir_pkg and bir_div
`default_nettype none

module bilinear_image_resize
   import bir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_item,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_item,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_COORD = 4'd2;
   localparam logic [3:0] S_RD0   = 4'd3;
   localparam logic [3:0] S_RD1   = 4'd4;
   localparam logic [3:0] S_RD2   = 4'd5;
   localparam logic [3:0] S_RD3   = 4'd6;
   localparam logic [3:0] S_MIX   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   localparam int R_BITS   = 2 * PIXEL_BITS + 3;
   localparam int D_BITS   = R_BITS + 1;
   localparam int ACC_BITS = D_BITS + FRAC_BITS + 2;

   // saturate a size register into [2, max]
   function automatic logic [SRC_SIZE_BITS-1:0] sat_size(
      input logic [SRC_SIZE_BITS-1:0] v,
      input logic [SRC_SIZE_BITS-1:0] hi
   );
      logic [SRC_SIZE_BITS-1:0] r;
      begin
         r = v;
         if (v < SRC_SIZE_BITS'(2)) r = SRC_SIZE_BITS'(2);
         else if (v > hi) r = hi;
         return r;
      end
   endfunction

   // q.16 numerator of the source coordinate for one axis
   function automatic logic [NUMER_BITS-1:0] axis_numer(
      input logic [COORD_BITS-1:0]    d,
      input logic [SRC_SIZE_BITS-1:0] s,
      input logic [DST_SIZE_BITS-1:0] dsz,
      input logic                     align
   );
      logic [7:0]  sm1;
      logic [19:0] p;
      logic [21:0] a;
      logic [20:0] n;
      begin
         sm1 = 8'(s - SRC_SIZE_BITS'(1));
         p   = 20'(sm1) * 20'(d);
         a   = 22'(s) * 22'({d, 1'b1});
         n   = (a > 22'(dsz)) ? 21'(a - 22'(dsz)) : '0;
         if (align) return {1'b0, p, 16'h0000};
         else return {n, 16'h0000};
      end
   endfunction

   function automatic logic [DENOM_BITS-1:0] axis_denom(
      input logic [DST_SIZE_BITS-1:0] dsz,
      input logic                     align
   );
      logic [DENOM_BITS-1:0] r;
      begin
         if (!align) r = {dsz, 1'b0};
         else if (dsz <= DST_SIZE_BITS'(1)) r = DENOM_BITS'(1);
         else r = DENOM_BITS'(dsz - DST_SIZE_BITS'(1));
         return r;
      end
   endfunction

   // clamp the coordinate and split it into lower neighbor and weight
   function automatic axis_type axis_split(
      input logic [QUOT_BITS-1:0]     q,
      input logic [SRC_SIZE_BITS-1:0] s
   );
      logic [ROW_BITS-1:0]  sm1;
      logic [ROW_BITS-1:0]  sm2;
      logic [QUOT_BITS-1:0] lim;
      logic [QUOT_BITS-1:0] c;
      logic [QUOT_BITS-1:0] diff;
      axis_type             r;
      begin
         sm1    = ROW_BITS'(s - SRC_SIZE_BITS'(1));
         sm2    = ROW_BITS'(s - SRC_SIZE_BITS'(2));
         lim    = {sm1, 16'h0000};
         c      = (q > lim) ? lim : q;
         r.base = (c[QUOT_BITS-1:FRAC_BITS] > sm2) ? sm2 : c[QUOT_BITS-1:FRAC_BITS];
         diff   = c - {r.base, 16'h0000};
         r.frac = diff[WEIGHT_BITS-1:0];
         return r;
      end
   endfunction

   logic [SRC_SIZE_BITS-1:0] source_height_ff, source_width_ff;
   logic [DST_SIZE_BITS-1:0] target_height_ff, target_width_ff;
   logic                     align_corners_ff;
   logic [SRC_SIZE_BITS-1:0] sh_eff, sw_eff;

   logic [3:0]               state_ff, state_in;
   logic                     req_accept;
   logic                     req_oor;
   logic                     store_ok;
   logic                     mem_we;
   logic [ADDR_BITS-1:0]     mem_addr;
   logic signed [PIXEL_BITS-1:0] plane_mem [SOURCE_DEPTH];
   logic signed [PIXEL_BITS-1:0] rd_data_ff;

   logic                     div_load;
   logic [QUOT_BITS-1:0]     row_quot, col_quot;
   logic                     row_done, col_done;

   axis_type                 y_ff, x_ff;
   logic [ROW_BITS-1:0]      y1, x1;
   logic signed [PIXEL_BITS-1:0] q00_ff, q10_ff;
   logic signed [R_BITS-1:0] r0_ff, r1_ff, r_in;
   logic signed [PIXEL_BITS:0]   q_diff;
   logic signed [PIXEL_BITS-1:0] q_base;
   logic signed [WEIGHT_BITS:0]  fx_s, fy_s;
   logic signed [D_BITS-1:0]     r_diff;
   logic signed [ACC_BITS-1:0]   acc;

   logic                     rsp_strobe_ff;
   rsp_type                  rsp_ff;

   assign sh_eff     = sat_size(source_height_ff, SRC_SIZE_BITS'(MAX_SOURCE_ROWS));
   assign sw_eff     = sat_size(source_width_ff, SRC_SIZE_BITS'(MAX_SOURCE_COLS));
   assign busy       = (state_ff != S_IDLE);
   assign req_accept = start && !busy;
   assign req_oor    = ({1'b0, req_item.row} >= target_height_ff)
                    || ({1'b0, req_item.col} >= target_width_ff);
   assign store_ok   = (req_item.row < COORD_BITS'(sh_eff)) && (req_item.col < COORD_BITS'(sw_eff));
   assign mem_we     = req_accept && (req_item.action == ACT_STORE) && store_ok;
   assign div_load   = req_accept && (req_item.action == ACT_REQUEST) && !req_oor;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_height_ff <= SRC_SIZE_BITS'(256);
         source_width_ff  <= SRC_SIZE_BITS'(256);
         target_height_ff <= DST_SIZE_BITS'(256);
         target_width_ff  <= DST_SIZE_BITS'(256);
         align_corners_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SOURCE_HEIGHT: source_height_ff <= csr_data[SRC_SIZE_BITS-1:0];
            REG_SOURCE_WIDTH:  source_width_ff  <= csr_data[SRC_SIZE_BITS-1:0];
            REG_TARGET_HEIGHT: target_height_ff <= csr_data[DST_SIZE_BITS-1:0];
            REG_TARGET_WIDTH:  target_width_ff  <= csr_data[DST_SIZE_BITS-1:0];
            REG_ALIGN_CORNERS: align_corners_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   bir_div u_row_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .numer (axis_numer(req_item.row, sh_eff, target_height_ff, align_corners_ff)),
      .denom (axis_denom(target_height_ff, align_corners_ff)),
      .quot  (row_quot),
      .done  (row_done)
   );

   bir_div u_col_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .numer (axis_numer(req_item.col, sw_eff, target_width_ff, align_corners_ff)),
      .denom (axis_denom(target_width_ff, align_corners_ff)),
      .quot  (col_quot),
      .done  (col_done)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (div_load) state_in = S_DIV;
         S_DIV:   if (row_done && col_done) state_in = S_COORD;
         S_COORD: state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_MIX;
         S_MIX:   state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // neighbor addresses, one per read cycle
   assign y1 = y_ff.base + 1'b1;
   assign x1 = x_ff.base + 1'b1;

   always_comb begin
      case (state_ff)
         S_IDLE:  mem_addr = {req_item.row[ROW_BITS-1:0], req_item.col[COL_BITS-1:0]};
         S_RD0:   mem_addr = {y_ff.base, x_ff.base};
         S_RD1:   mem_addr = {y_ff.base, x1};
         S_RD2:   mem_addr = {y1, x_ff.base};
         S_RD3:   mem_addr = {y1, x1};
         default: mem_addr = {y_ff.base, x_ff.base};
      endcase
   end

   // single port source plane
   always_ff @(posedge clock) begin
      if (mem_we) plane_mem[mem_addr] <= req_item.pixel;
      else rd_data_ff <= plane_mem[mem_addr];
   end

   // horizontal blend: q_base*65536 + fx*(q_next - q_base)
   always_comb begin
      q_base = (state_ff == S_MIX) ? q10_ff : q00_ff;
      q_diff = (PIXEL_BITS + 1)'(rd_data_ff) - (PIXEL_BITS + 1)'(q_base);
      fx_s   = $signed({1'b0, x_ff.frac});
      fy_s   = $signed({1'b0, y_ff.frac});
      r_in   = (R_BITS'(q_base) <<< FRAC_BITS) + fx_s * q_diff;
      r_diff = D_BITS'(r1_ff) - D_BITS'(r0_ff);
      acc    = (ACC_BITS'(r0_ff) <<< FRAC_BITS) + fy_s * r_diff
             + $signed(ACC_BITS'(64'sd2147483648));
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_COORD) begin
         y_ff <= axis_split(row_quot, sh_eff);
         x_ff <= axis_split(col_quot, sw_eff);
      end
      if (state_ff == S_RD1) q00_ff <= rd_data_ff;
      if (state_ff == S_RD2) r0_ff  <= r_in;
      if (state_ff == S_RD3) q10_ff <= rd_data_ff;
      if (state_ff == S_MIX) r1_ff  <= r_in;
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= (req_accept && (req_item.action == ACT_REQUEST) && req_oor)
                         || (state_ff == S_FIN);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN) begin
         rsp_ff.value        <= acc[2*FRAC_BITS+PIXEL_BITS-1:2*FRAC_BITS];
         rsp_ff.out_of_range <= 1'b0;
      end else if (req_accept) begin
         rsp_ff.value        <= '0;
         rsp_ff.out_of_range <= 1'b1;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_flag_next: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_item.action == ACT_REQUEST && req_oor
      |=> rsp_strobe && rsp_item.out_of_range)
      else $error("flagged request gave no flagged word");

   a_busy_on_request: assert property (@(posedge clock) disable iff (reset)
      div_load |=> busy && !rsp_strobe)
      else $error("in-range request did not raise busy");

   a_done_with_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && !rsp_item.out_of_range)
      else $error("busy dropped without an interpolated word");

endmodule

`default_nettype wire
